// File: hw/rtl/crc32ws_pkg.sv
// shared constants and the byte step of the reflected crc-32
`timescale 1ns / 1ps

package crc32ws_pkg;

   localparam int unsigned CRC_W     = 32;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MAX_BYTES = CRC_W / BYTE_W;
   localparam int unsigned COUNT_W   = 3;
   localparam int unsigned SEL_W     = $clog2(MAX_BYTES + 1);

   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   // one byte through the lsb-first shift register, same as the table form
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/crc32ws_lane.sv
// one lane: running crc advanced over a fixed number of leading bytes
`timescale 1ns / 1ps

module crc32ws_lane #(
   parameter int unsigned NUM_BYTES = crc32ws_pkg::MAX_BYTES
) (
   input  logic [crc32ws_pkg::CRC_W-1:0] crc_in,
   input  logic [crc32ws_pkg::CRC_W-1:0] data_word,
   output logic [crc32ws_pkg::CRC_W-1:0] crc_out
);
   import crc32ws_pkg::*;

   logic [CRC_W-1:0] stage [NUM_BYTES+1];

   assign stage[0] = crc_in;

   // bytes taken from the top of the word downward
   for (genvar i = 0; i < NUM_BYTES; i++) begin : g_step
      assign stage[i+1] = crc_byte(stage[i], data_word[CRC_W-1-BYTE_W*i -: BYTE_W]);
   end

   assign crc_out = stage[NUM_BYTES];

endmodule

// File: hw/rtl/crc32ws_merge.sv
// picks the lane that matches the byte count and forms next state and result
`timescale 1ns / 1ps

module crc32ws_merge (
   input  logic [crc32ws_pkg::MAX_BYTES:0][crc32ws_pkg::CRC_W-1:0] lane_crc,
   input  logic [crc32ws_pkg::COUNT_W-1:0]                         byte_count,
   input  logic                                                    last_word,
   output logic [crc32ws_pkg::CRC_W-1:0]                           next_crc,
   output logic [crc32ws_pkg::CRC_W-1:0]                           result_crc
);
   import crc32ws_pkg::*;

   logic [SEL_W-1:0] sel;
   logic [CRC_W-1:0] picked;

   // counts above four saturate, zero keeps the running value
   always_comb begin
      if (byte_count > COUNT_W'(MAX_BYTES)) begin
         sel = SEL_W'(MAX_BYTES);
      end else begin
         sel = SEL_W'(byte_count);
      end
      picked     = lane_crc[sel];
      result_crc = ~picked;
      next_crc   = last_word ? CRC_INIT : picked;
   end

endmodule

// File: hw/rtl/crc32_word_stream.sv
// streaming crc-32 over 32-bit words with byte counts, top level
`timescale 1ns / 1ps

// Takes one message word per cycle, with no gaps between words or messages, unless
// a last word is stalled. The running CRC register feeds four lanes that advance it
// by one to four leading bytes of the word, and a count select closes that loop.
// A transfer flagged last leaves the inverted CRC in the output register on the
// next cycle and restarts the CRC at all ones. Non-last words are taken even while
// a result is held; a last word is stalled only while a held result is stalled.
module crc32_word_stream (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [crc32ws_pkg::CRC_W-1:0]         req_data_word,
   input  logic [crc32ws_pkg::COUNT_W-1:0]       req_byte_count,
   input  logic                                  req_last_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [crc32ws_pkg::CRC_W-1:0]         rsp_crc_value
);
   import crc32ws_pkg::*;

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff, rsp_crc_in;

   logic [MAX_BYTES:0][CRC_W-1:0] lane_crc;
   logic [CRC_W-1:0]              next_crc;
   logic [CRC_W-1:0]              result_crc;
   logic                          req_xfer;

   assign lane_crc[0] = crc_ff;

   for (genvar n = 1; n <= MAX_BYTES; n++) begin : g_lane
      crc32ws_lane #(
         .NUM_BYTES(n)
      ) u_lane (
         .crc_in   (crc_ff),
         .data_word(req_data_word),
         .crc_out  (lane_crc[n])
      );
   end

   crc32ws_merge u_merge (
      .lane_crc  (lane_crc),
      .byte_count(req_byte_count),
      .last_word (req_last_word),
      .next_crc  (next_crc),
      .result_crc(result_crc)
   );

   // only a last word needs the output register
   assign req_stall = rsp_valid_ff & rsp_stall & req_last_word;
   assign req_xfer  = req_valid & ~req_stall;

   always_comb begin
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         crc_in = next_crc;
         if (req_last_word) begin
            rsp_valid_in = 1'b1;
            rsp_crc_in   = result_crc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_last_word |=> rsp_valid)
      else $error("last word transfer did not produce a result");

   a_last_reloads: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_last_word |=> crc_ff == CRC_INIT)
      else $error("crc not reloaded after last word");

   a_empty_word_holds: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_last_word && req_byte_count == '0 |=> $stable(crc_ff))
      else $error("zero byte word changed the running crc");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled with output free");

   a_result_kept_by_nonlast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value))
      else $error("held result lost or changed");
`endif

endmodule
